### rtl/core/ray_box_nearest_pick_defines.svh
// Assertion macros for the ray box nearest pick block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RAY_BOX_NEAREST_PICK_DEFINES_SVH
`define RAY_BOX_NEAREST_PICK_DEFINES_SVH
`ifndef SYNTHESIS
`define RBNP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RBNP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define RBNP_ASSERT(lbl, clk, rstn, prop, msg)
`define RBNP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

### rtl/core/rbnp_pkg.sv
// Shared constants, types and state encodings of the ray box nearest pick block.
// No dependencies; every RTL module imports it, the interfaces in rbnp_if.sv do not.
package rbnp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_ENTRIES = 1024;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int DIST_W      = 31;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int UNIT_W      = FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] EPS_SQ =
        (64'd1 << (2 * FRAC_BITS)) / 64'd10000000000;
    localparam logic [UNIT_W-1:0] DIR_EPS =
        UNIT_W'((64'd1 << FRAC_BITS) / 64'd10000000);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [NUM_W-1:0] INV_NUM = NUM_W'(64'd1 << (2 * FRAC_BITS));
    localparam logic [DATA_W-1:0] INV_SAT = 32'h7FFF_FFFF;
    localparam logic signed [32:0] SAT_DIST = {2'b01, 31'd0};

    typedef enum logic {
        KIND_HEADER,
        KIND_BOX
    } item_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic                    entry_active;
        logic [2:0][DATA_W-1:0]  a;
        logic [2:0][DATA_W-1:0]  b;
        logic [DATA_W-1:0]       max_distance;
        logic                    maxd_pos;
        logic                    last;
    } rbnp_item_t;

    typedef struct packed {
        logic              query_rejected;
        logic              found;
        logic [IDX_W-1:0]  hit_index;
        logic [DIST_W-1:0] hit_distance;
    } rbnp_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HSQ,
        ST_HCHK,
        ST_HSQRT,
        ST_HUDIV,
        ST_HUWAIT,
        ST_HIDIV,
        ST_HIWAIT,
        ST_BDIFF,
        ST_BMUL,
        ST_BACC,
        ST_BDEC,
        ST_REPORT
    } back_state_t;

endpackage

### rtl/core/rbnp_if.sv
// Channel interfaces of the ray box nearest pick block: input words and result words.
// Plain valid/ready channels; no dependencies.
interface rbnp_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        entry_active;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    logic [31:0] max_distance;
    logic        last;

    modport source (output valid, func, entry_active, ax, ay, az, bx, by, bz,
                    max_distance, last, input ready);
    modport sink (input valid, func, entry_active, ax, ay, az, bx, by, bz,
                  max_distance, last, output ready);
endinterface

interface rbnp_out_if;
    logic        valid;
    logic        ready;
    logic        query_rejected;
    logic        found;
    logic [9:0]  hit_index;
    logic [30:0] hit_distance;

    modport source (output valid, query_rejected, found, hit_index, hit_distance,
                    input ready);
    modport sink (input valid, query_rejected, found, hit_index, hit_distance,
                  output ready);
endinterface

### rtl/core/rbnp_front.sv
// Front end: accepts input words and classifies them into queue entries.
// Depends on rbnp_pkg and rbnp_in_if.
module rbnp_front
    import rbnp_pkg::*;
(
    rbnp_in_if.sink     items,
    input  logic        full,
    output logic        push,
    output rbnp_item_t  item
);

    assign items.ready = !full;
    assign push        = items.valid && !full;

    always_comb
    begin
        item.kind         = items.func ? KIND_BOX : KIND_HEADER;
        item.entry_active = items.entry_active;
        item.a            = {items.az, items.ay, items.ax};
        item.b            = {items.bz, items.by, items.bx};
        item.max_distance = items.max_distance;
        // A header limit must be strictly positive to open a query.
        item.maxd_pos     = !items.max_distance[DATA_W-1] && (|items.max_distance);
        item.last         = items.last;
    end

endmodule

### rtl/core/rbnp_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on rbnp_pkg.
module rbnp_queue
    import rbnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rbnp_item_t  push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output rbnp_item_t  head
);

    rbnp_item_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/rbnp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the ray setup steps.
// Depends on rbnp_pkg.
module rbnp_divider
    import rbnp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numerator,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    localparam int CW = $clog2(NUM_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DATA_W:0]   shifted;
    logic              ge;

    assign shifted  = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= divisor;
                quo_reg  <= numerator;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DATA_W'(shifted - {1'b0, den_reg}) : shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/rbnp_back.sv
// Back end: ray setup (length, square root, unit and inverse direction) and
// per-box slab tests, with the result output register. Depends on rbnp_pkg,
// rbnp_divider, rbnp_out_if and the assertion macros.
`include "ray_box_nearest_pick_defines.svh"
module rbnp_back
    import rbnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  rbnp_item_t  q_item,
    output logic        q_pop,
    rbnp_out_if.source  results
);

    back_state_t             state_reg, state_next;
    rbnp_item_t              cur_reg, cur_next;
    logic [2:0][DATA_W-1:0]  origin_reg, origin_next;
    logic [2:0][DATA_W-1:0]  unit_reg, unit_next;
    logic [2:0][DATA_W-1:0]  inv_reg, inv_next;
    logic signed [DATA_W-1:0] nearest_reg, nearest_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic                    hit_seen_reg, hit_seen_next;
    logic                    query_valid_reg, query_valid_next;
    logic [CNT_W-1:0]        box_count_reg, box_count_next;
    logic [1:0]              ax_reg, ax_next;
    logic                    side_reg, side_next;
    logic [63:0]             lsq_reg, lsq_next;
    logic [63:0]             rad_reg, rad_next;
    logic [33:0]             rem_reg, rem_next;
    logic [31:0]             root_reg, root_next;
    logic [4:0]              iter_reg, iter_next;
    logic [UNIT_W-1:0]       um_reg, um_next;
    logic signed [33:0]      diff_reg, diff_next;
    logic [65:0]             prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic signed [32:0]      t0_reg, t0_next;
    logic signed [32:0]      nr_reg, nr_next;
    logic signed [32:0]      fr_reg, fr_next;
    logic                    fail_reg, fail_next;
    rbnp_result_t            res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DATA_W-1:0]       div_den;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;

    // Per-axis operands of the current word.
    logic signed [33:0]      c_ext, h_ext, o_ext, lo_ext, hi_ext;
    logic [DATA_W-1:0]       b_mag;
    logic [33:0]             diff_mag;
    logic [DATA_W-1:0]       inv_mag;
    logic [DATA_W-1:0]       u_val;
    logic [UNIT_W-1:0]       u_mag;
    logic signed [32:0]      m_val, t_val, t_lo, t_hi, nr_new, fr_new;
    logic [35:0]             sq_shift, sq_trial;
    logic [DATA_W-1:0]       im_val;
    logic signed [32:0]      nearest_ext;
    logic                    res_free;

    rbnp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quot)
    );

    assign c_ext    = 34'($signed(cur_reg.a[ax_reg]));
    assign h_ext    = 34'($signed(cur_reg.b[ax_reg]));
    assign o_ext    = 34'($signed(origin_reg[ax_reg]));
    assign lo_ext   = c_ext - h_ext;
    assign hi_ext   = c_ext + h_ext;
    assign b_mag    = cur_reg.b[ax_reg][DATA_W-1] ? (~cur_reg.b[ax_reg] + 1'b1)
                                                 : cur_reg.b[ax_reg];
    assign diff_mag = diff_reg[33] ? 34'(-diff_reg) : 34'(diff_reg);
    assign inv_mag  = inv_reg[ax_reg][DATA_W-1] ? (~inv_reg[ax_reg] + 1'b1) : inv_reg[ax_reg];
    assign u_val    = unit_reg[ax_reg];
    assign u_mag    = u_val[DATA_W-1] ? UNIT_W'(~u_val + 1'b1) : UNIT_W'(u_val);

    // A product at or above 2^(31+F) saturates the slab distance to 2^31.
    assign m_val = (|prod_reg[65:31+FRAC_BITS]) ? SAT_DIST
                                                : {2'b00, prod_reg[30+FRAC_BITS:FRAC_BITS]};
    assign t_val = neg_reg ? -m_val : m_val;
    assign t_lo  = (t0_reg > t_val) ? t_val : t0_reg;
    assign t_hi  = (t0_reg > t_val) ? t0_reg : t_val;
    assign nr_new = (t_lo > nr_reg) ? t_lo : nr_reg;
    assign fr_new = (t_hi < fr_reg) ? t_hi : fr_reg;

    assign sq_shift = {rem_reg, rad_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    assign im_val      = (|div_quot[NUM_W-1:31]) ? INV_SAT : {1'b0, div_quot[30:0]};
    assign nearest_ext = 33'(nearest_reg);
    assign res_free    = !res_valid_reg || results.ready;

    assign results.valid          = res_valid_reg;
    assign results.query_rejected = res_reg.query_rejected;
    assign results.found          = res_reg.found;
    assign results.hit_index      = res_reg.hit_index;
    assign results.hit_distance   = res_reg.hit_distance;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        origin_next      = origin_reg;
        unit_next        = unit_reg;
        inv_next         = inv_reg;
        nearest_next     = nearest_reg;
        best_next        = best_reg;
        hit_seen_next    = hit_seen_reg;
        query_valid_next = query_valid_reg;
        box_count_next   = box_count_reg;
        ax_next          = ax_reg;
        side_next        = side_reg;
        lsq_next         = lsq_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        iter_next        = iter_reg;
        um_next          = um_reg;
        diff_next        = diff_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        t0_next          = t0_reg;
        nr_next          = nr_reg;
        fr_next          = fr_reg;
        fail_next        = fail_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && !results.ready;
        q_pop            = 1'b0;
        div_start        = 1'b0;
        div_num          = '0;
        div_den          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    ax_next  = '0;
                    if (q_item.kind == KIND_HEADER)
                    begin
                        lsq_next   = '0;
                        state_next = ST_HSQ;
                    end
                    else
                    begin
                        side_next = 1'b0;
                        fail_next = 1'b0;
                        nr_next   = '0;
                        fr_next   = SAT_DIST;
                        state_next = q_item.last ? ST_REPORT : ST_IDLE;
                        if (query_valid_reg && (box_count_reg < CNT_MAX))
                        begin
                            if (q_item.entry_active)
                            begin
                                state_next = ST_BDIFF;
                            end
                            else
                            begin
                                box_count_next = box_count_reg + 1'b1;
                            end
                        end
                    end
                end
            end

            ST_HSQ:
            begin
                lsq_next = lsq_reg + (64'(b_mag) * 64'(b_mag));
                if (ax_reg == 2'd2)
                begin
                    state_next = ST_HCHK;
                end
                else
                begin
                    ax_next = ax_reg + 1'b1;
                end
            end

            ST_HCHK:
            begin
                box_count_next   = '0;
                hit_seen_next    = 1'b0;
                best_next        = '0;
                query_valid_next = cur_reg.maxd_pos && (lsq_reg > EPS_SQ);
                if (cur_reg.maxd_pos && (lsq_reg > EPS_SQ))
                begin
                    nearest_next = $signed(cur_reg.max_distance);
                    origin_next  = cur_reg.a;
                    rad_next     = lsq_reg;
                    rem_next     = '0;
                    root_next    = '0;
                    iter_next    = '0;
                    state_next   = ST_HSQRT;
                end
                else
                begin
                    nearest_next = '0;
                    state_next   = cur_reg.last ? ST_REPORT : ST_IDLE;
                end
            end

            ST_HSQRT:
            begin
                rad_next  = {rad_reg[61:0], 2'b00};
                iter_next = iter_reg + 1'b1;
                if (sq_shift >= sq_trial)
                begin
                    rem_next  = 34'(sq_shift - sq_trial);
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_shift[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                if (&iter_reg)
                begin
                    ax_next    = '0;
                    state_next = ST_HUDIV;
                end
            end

            ST_HUDIV:
            begin
                div_start  = 1'b1;
                div_num    = NUM_W'(b_mag) << FRAC_BITS;
                div_den    = (root_reg == '0) ? DATA_W'(1) : root_reg;
                state_next = ST_HUWAIT;
            end

            ST_HUWAIT:
            begin
                if (div_done)
                begin
                    um_next = div_quot[UNIT_W-1:0];
                    unit_next[ax_reg] = cur_reg.b[ax_reg][DATA_W-1]
                                        ? -DATA_W'(div_quot[UNIT_W-1:0])
                                        : DATA_W'(div_quot[UNIT_W-1:0]);
                    if (div_quot[UNIT_W-1:0] <= DIR_EPS)
                    begin
                        // Near-zero axis: no reciprocal, tested by containment.
                        inv_next[ax_reg] = '0;
                        if (ax_reg == 2'd2)
                        begin
                            state_next = cur_reg.last ? ST_REPORT : ST_IDLE;
                        end
                        else
                        begin
                            ax_next    = ax_reg + 1'b1;
                            state_next = ST_HUDIV;
                        end
                    end
                    else
                    begin
                        state_next = ST_HIDIV;
                    end
                end
            end

            ST_HIDIV:
            begin
                div_start  = 1'b1;
                div_num    = INV_NUM;
                div_den    = DATA_W'(um_reg);
                state_next = ST_HIWAIT;
            end

            ST_HIWAIT:
            begin
                if (div_done)
                begin
                    inv_next[ax_reg] = cur_reg.b[ax_reg][DATA_W-1] ? -im_val : im_val;
                    if (ax_reg == 2'd2)
                    begin
                        state_next = cur_reg.last ? ST_REPORT : ST_IDLE;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_HUDIV;
                    end
                end
            end

            ST_BDIFF:
            begin
                if (u_mag <= DIR_EPS)
                begin
                    if ((o_ext < lo_ext) || (o_ext > hi_ext))
                    begin
                        fail_next = 1'b1;
                    end
                    if (ax_reg == 2'd2)
                    begin
                        state_next = ST_BDEC;
                    end
                    else
                    begin
                        ax_next = ax_reg + 1'b1;
                    end
                end
                else
                begin
                    diff_next  = (side_reg ? hi_ext : lo_ext) - o_ext;
                    state_next = ST_BMUL;
                end
            end

            ST_BMUL:
            begin
                prod_next  = 66'(diff_mag) * 66'(inv_mag);
                neg_next   = diff_reg[33] != inv_reg[ax_reg][DATA_W-1];
                state_next = ST_BACC;
            end

            ST_BACC:
            begin
                state_next = ST_BDIFF;
                if (!side_reg)
                begin
                    t0_next   = t_val;
                    side_next = 1'b1;
                end
                else
                begin
                    nr_next   = nr_new;
                    fr_next   = fr_new;
                    side_next = 1'b0;
                    if (nr_new > fr_new)
                    begin
                        fail_next = 1'b1;
                    end
                    if (ax_reg == 2'd2)
                    begin
                        state_next = ST_BDEC;
                    end
                    else
                    begin
                        ax_next = ax_reg + 1'b1;
                    end
                end
            end

            ST_BDEC:
            begin
                // Equal distances replace the earlier box, so ties go to the later one.
                if (!fail_reg && (nr_reg < SAT_DIST) && (nr_reg <= nearest_ext))
                begin
                    nearest_next  = DATA_W'(nr_reg);
                    best_next     = IDX_W'(box_count_reg);
                    hit_seen_next = 1'b1;
                end
                box_count_next = box_count_reg + 1'b1;
                state_next     = cur_reg.last ? ST_REPORT : ST_IDLE;
            end

            ST_REPORT:
            begin
                if (res_free)
                begin
                    res_next.query_rejected = !query_valid_reg;
                    res_next.found          = query_valid_reg && hit_seen_reg;
                    res_next.hit_index      = (query_valid_reg && hit_seen_reg)
                                              ? best_reg : '0;
                    res_next.hit_distance   = (query_valid_reg && hit_seen_reg)
                                              ? nearest_reg[DIST_W-1:0] : '0;
                    res_valid_next   = 1'b1;
                    query_valid_next = 1'b0;
                    hit_seen_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            origin_reg      <= '0;
            unit_reg        <= '0;
            inv_reg         <= '0;
            nearest_reg     <= '0;
            best_reg        <= '0;
            hit_seen_reg    <= 1'b0;
            query_valid_reg <= 1'b0;
            box_count_reg   <= '0;
            ax_reg          <= '0;
            side_reg        <= 1'b0;
            lsq_reg         <= '0;
            rad_reg         <= '0;
            rem_reg         <= '0;
            root_reg        <= '0;
            iter_reg        <= '0;
            um_reg          <= '0;
            diff_reg        <= '0;
            prod_reg        <= '0;
            neg_reg         <= 1'b0;
            t0_reg          <= '0;
            nr_reg          <= '0;
            fr_reg          <= '0;
            fail_reg        <= 1'b0;
            res_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            origin_reg      <= origin_next;
            unit_reg        <= unit_next;
            inv_reg         <= inv_next;
            nearest_reg     <= nearest_next;
            best_reg        <= best_next;
            hit_seen_reg    <= hit_seen_next;
            query_valid_reg <= query_valid_next;
            box_count_reg   <= box_count_next;
            ax_reg          <= ax_next;
            side_reg        <= side_next;
            lsq_reg         <= lsq_next;
            rad_reg         <= rad_next;
            rem_reg         <= rem_next;
            root_reg        <= root_next;
            iter_reg        <= iter_next;
            um_reg          <= um_next;
            diff_reg        <= diff_next;
            prod_reg        <= prod_next;
            neg_reg         <= neg_next;
            t0_reg          <= t0_next;
            nr_reg          <= nr_next;
            fr_reg          <= fr_next;
            fail_reg        <= fail_next;
            res_reg         <= res_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    `RBNP_ASSERT(a_box_count_bound, clk, rst_n, box_count_reg <= CNT_MAX, "box count overflow")
    `RBNP_ASSERT(a_found_not_rejected, clk, rst_n, res_valid_reg && res_reg.found |-> !res_reg.query_rejected, "found on rejected query")
    `RBNP_ASSERT_NEXT(a_query_closes, clk, rst_n, state_reg == ST_REPORT && res_free, !query_valid_reg && res_valid_reg, "query not closed after result")

endmodule

### rtl/core/ray_box_nearest_pick.sv
// Nearest ray/box pick. Input words arrive on "items": a header word (func = 0)
// carries the ray origin, direction and distance limit and opens a query; box
// words (func = 1) carry a centre and half extents. One result word leaves on
// "results" for every input word marked last.
// A header sums the squared direction components, checks the query, then runs
// the direction length square root at one bit per cycle; the unit direction
// and reciprocal of each axis go through one shared divider at one quotient bit
// per cycle (48 quotient bits per division). A box is tested axis by axis: each
// tested axis needs two slab distances, each through a difference, multiply and
// accumulate step.
// Words are handled one at a time by the back end; a four-entry queue lets the
// input side keep taking words while the back end is busy.
// The result sits in an output register, written by the report step once that
// register is free. While the receiver stalls, the back end can finish the next
// query's work up to its own report and then waits.
// Reset clears the queue, the open query and the output register; no query is
// open afterwards, so a box word marked last reports a rejected query.
module ray_box_nearest_pick
    import rbnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rbnp_in_if.sink     items,
    rbnp_out_if.source  results
);

    logic        push;
    logic        full;
    logic        pop;
    logic        not_empty;
    rbnp_item_t  push_item;
    rbnp_item_t  head;

    rbnp_front u_front (
        .items (items),
        .full  (full),
        .push  (push),
        .item  (push_item)
    );

    rbnp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    rbnp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_item  (head),
        .q_pop   (pop),
        .results (results)
    );

endmodule

### verif/ray_box_nearest_pick_tb.sv
// Self-checking testbench for ray_box_nearest_pick: drives header and box words,
// predicts each query result and compares the result words field by field.
// Depends on rbnp_pkg and the channel interfaces in rbnp_if.sv.
module ray_box_nearest_pick_tb;
    import rbnp_pkg::*;

    typedef struct {
        bit        func;
        bit        entry_active;
        bit [31:0] ax, ay, az, bx, by, bz;
        bit [31:0] max_distance;
        bit        last;
    } pick_word_t;

    typedef struct {
        bit        query_rejected;
        bit        found;
        bit [9:0]  hit_index;
        bit [30:0] hit_distance;
    } pick_result_t;

    localparam longint SAT_D = 64'sd1 << 31;
    localparam longint AXIS_EPS = (64'sd1 << FRAC_BITS) / 10000000;
    localparam longint unsigned SQ_EPS = (64'd1 << (2 * FRAC_BITS)) / 64'd10000000000;
    localparam longint unsigned PROD_MAX = (64'd1 << (31 + FRAC_BITS)) - 1;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    rbnp_in_if  items ();
    rbnp_out_if results ();

    ray_box_nearest_pick dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    // Predictor state.
    longint origin[3], unit_dir[3], inv_dir[3];
    longint nearest;
    int unsigned best_pos, box_pos;
    bit hit_any, query_open;

    pick_word_t   pending_words[$];
    pick_result_t expected_results[$];
    int  error_count;
    int  cycle_count;
    bit  stimulus_done;
    int  send_gap, recv_gap;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sext(bit [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_slab(longint a, longint inv);
        longint unsigned ma, mb, m;
        bit neg;
        neg = (a < 0) != (inv < 0);
        ma = magnitude(a);
        mb = magnitude(inv);
        if (mb == 0) return 0;
        if (ma > PROD_MAX / mb) m = SAT_D;
        else m = (ma * mb) >> FRAC_BITS;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit slab_hit(int ax_i, longint c, longint h,
                                    ref longint t_near, ref longint t_far);
        longint lo, hi, t1, t2, tmp;
        lo = c - h;
        hi = c + h;
        if (unit_dir[ax_i] <= AXIS_EPS && unit_dir[ax_i] >= -AXIS_EPS)
            return origin[ax_i] >= lo && origin[ax_i] <= hi;
        t1 = scale_slab(lo - origin[ax_i], inv_dir[ax_i]);
        t2 = scale_slab(hi - origin[ax_i], inv_dir[ax_i]);
        if (t1 > t2)
        begin
            tmp = t1;
            t1 = t2;
            t2 = tmp;
        end
        if (t1 > t_near) t_near = t1;
        if (t2 < t_far) t_far = t2;
        return t_near <= t_far;
    endfunction

    // Advances the pick state by one word; pushes a result on a last word.
    task automatic predict_pick(pick_word_t w);
        longint a[3], b[3], maxd, u, tn, tf;
        longint unsigned lsq, len, um, im;
        bit hit;
        pick_result_t r;
        a[0] = sext(w.ax); a[1] = sext(w.ay); a[2] = sext(w.az);
        b[0] = sext(w.bx); b[1] = sext(w.by); b[2] = sext(w.bz);
        if (w.func == KIND_HEADER)
        begin
            maxd = sext(w.max_distance);
            lsq = 0;
            for (int i = 0; i < 3; i++) lsq += magnitude(b[i]) * magnitude(b[i]);
            box_pos = 0;
            hit_any = 0;
            best_pos = 0;
            query_open = !(maxd <= 0 || lsq <= SQ_EPS);
            nearest = query_open ? maxd : 0;
            if (query_open)
            begin
                len = int_sqrt(lsq);
                if (len == 0) len = 1;
                for (int i = 0; i < 3; i++)
                begin
                    um = (magnitude(b[i]) << FRAC_BITS) / len;
                    u = b[i] < 0 ? -longint'(um) : longint'(um);
                    origin[i] = a[i];
                    unit_dir[i] = u;
                    if (u <= AXIS_EPS && u >= -AXIS_EPS)
                        inv_dir[i] = 0;
                    else
                    begin
                        im = (64'd1 << (2 * FRAC_BITS)) / um;
                        if (im > 64'h7FFF_FFFF) im = 64'h7FFF_FFFF;
                        inv_dir[i] = u < 0 ? -longint'(im) : longint'(im);
                    end
                end
            end
        end
        else if (query_open && box_pos < MAX_ENTRIES)
        begin
            if (w.entry_active)
            begin
                tn = 0;
                tf = SAT_D;
                hit = slab_hit(0, a[0], b[0], tn, tf);
                if (hit) hit = slab_hit(1, a[1], b[1], tn, tf);
                if (hit) hit = slab_hit(2, a[2], b[2], tn, tf);
                if (hit && tn < SAT_D && tn <= nearest)
                begin
                    nearest = tn;
                    best_pos = box_pos;
                    hit_any = 1;
                end
            end
            box_pos++;
        end
        if (w.last)
        begin
            r.query_rejected = !query_open;
            r.found = query_open && hit_any;
            r.hit_index = r.found ? best_pos[9:0] : '0;
            r.hit_distance = r.found ? nearest[30:0] : '0;
            expected_results.push_back(r);
            query_open = 0;
            hit_any = 0;
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic bit [31:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return $urandom;
        if (p == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
    endfunction

    function automatic pick_word_t make_header(bit last);
        pick_word_t w;
        int p;
        w.func = KIND_HEADER;
        w.entry_active = ($urandom_range(0, 1) != 0);
        w.ax = rand_coord(); w.ay = rand_coord(); w.az = rand_coord();
        w.bx = rand_coord(); w.by = rand_coord(); w.bz = rand_coord();
        p = $urandom_range(0, 9);
        if (p == 0) w.bx = 0;
        if (p <= 1) w.by = 0;
        if (p == 2) w.bz = $urandom_range(0, 3);
        p = $urandom_range(0, 19);
        if (p == 0) w.max_distance = $urandom;
        else if (p == 1) w.max_distance = 0;
        else if (p == 2) w.max_distance = 32'h7FFF_FFFF;
        else w.max_distance = $urandom_range(1, 60 << 16);
        w.last = last;
        return w;
    endfunction

    function automatic pick_word_t make_box(bit last);
        pick_word_t w;
        w.func = KIND_BOX;
        w.entry_active = $urandom_range(0, 7) != 0;
        w.ax = rand_coord(); w.ay = rand_coord(); w.az = rand_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            w.bx = $urandom; w.by = $urandom; w.bz = $urandom;
        end
        else
        begin
            w.bx = 32'(signed'($urandom_range(0, 8 << 16)) - (1 << 16));
            w.by = $urandom_range(0, 8 << 16);
            w.bz = $urandom_range(0, 8 << 16);
        end
        w.max_distance = $urandom;
        w.last = last;
        return w;
    endfunction

    function automatic pick_word_t directed_word(bit func, bit act,
            bit [31:0] ox, bit [31:0] oy, bit [31:0] oz, bit [31:0] dx,
            bit [31:0] dy, bit [31:0] dz, bit [31:0] md, bit last);
        pick_word_t w;
        w.func = func; w.entry_active = act;
        w.ax = ox; w.ay = oy; w.az = oz;
        w.bx = dx; w.by = dy; w.bz = dz;
        w.max_distance = md; w.last = last;
        return w;
    endfunction

    initial
    begin
        int n, boxes;
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stimulus_done = 0;
        // Box before any header, then headers rejected for distance and length.
        pending_words.push_back(directed_word(1'b1, 1'b1, 0, 0, 0, 1, 1, 1, 0, 1'b1));
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 1 << 16, 0, 0, 0,
                                              1'b1));
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 32'h10000,
                                              1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 0, 0, 0, 1, 1, 1, 0, 1'b1));
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 1 << 16, 0, 0,
                                              32'hFFFF_FFFF, 1'b1));
        // Ray along +x with two equal-distance boxes: the later one wins.
        pending_words.push_back(directed_word(1'b0, 1'b1, 0, 0, 0, 1 << 16, 0, 0,
                                              32'h7FFF_FFFF, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 10 << 16, 0, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 10 << 16, 0, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b0, 2 << 16, 0, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b0));
        // Negative extents, origin outside the y slab, extreme values.
        pending_words.push_back(directed_word(1'b1, 1'b1, 5 << 16, 0, 0, 32'hFFFF_0000,
                                              32'hFFFF_0000, 32'hFFFF_0000, 0, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 5 << 16, 5 << 16, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b1));
        // Box after a finished query is ignored.
        pending_words.push_back(directed_word(1'b1, 1'b1, 0, 0, 0, 1 << 16, 1 << 16,
                                              1 << 16, 0, 1'b1));
        // Extreme direction, box behind the ray, short limit, header then header.
        pending_words.push_back(directed_word(1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                                              0, 32'h8000_0000, 32'h8000_0000,
                                              32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 0, 32'hFFFF_0000, 0,
                                              3 << 16, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 0, 2 << 16, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b0));
        pending_words.push_back(directed_word(1'b1, 1'b1, 0, 32'hFFF6_0000, 0, 1 << 16,
                                              1 << 16, 1 << 16, 0, 1'b1));
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 3, 0, 0, 5, 1'b1));
        // Overflow of the box sequence: 1030 boxes, those past the first 1024 not tested.
        pending_words.push_back(directed_word(1'b0, 1'b0, 0, 0, 0, 1 << 16, 0, 0,
                                              32'h7FFF_FFFF, 1'b0));
        for (int i = 0; i < 1030; i++)
            pending_words.push_back(directed_word(1'b1, i > 1020, (2000 - i) << 16, 0, 0,
                                                  1 << 16, 1 << 16, 1 << 16, 0,
                                                  i == 1029));
        n = 0;
        while (n < 200)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pending_words.push_back($urandom_range(0, 1)
                                        ? make_box($urandom_range(0, 1) != 0)
                                        : make_header($urandom_range(0, 1) != 0));
                n++;
            end
            else
            begin
                pending_words.push_back(make_header($urandom_range(0, 19) == 0));
                boxes = $urandom_range(0, 6);
                for (int i = 0; i < boxes; i++)
                    pending_words.push_back(make_box(i == boxes - 1));
                n += boxes + 1;
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            items.valid <= 1'b0;
            items.func <= 1'b0;
            items.entry_active <= 1'b0;
            items.ax <= '0; items.ay <= '0; items.az <= '0;
            items.bx <= '0; items.by <= '0; items.bz <= '0;
            items.max_distance <= '0;
            items.last <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            gap = send_gap;
            if (items.valid && items.ready)
            begin
                predict_pick(pending_words.pop_front());
                // Some accepted words are followed by an idle gap.
                gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
            else if (!items.valid && gap > 0)
                gap = gap - 1;
            if (items.valid && !items.ready)
                items.valid <= 1'b1;
            else if (gap == 0 && pending_words.size() > 0)
            begin
                items.valid <= 1'b1;
                items.func <= pending_words[0].func;
                items.entry_active <= pending_words[0].entry_active;
                items.ax <= pending_words[0].ax;
                items.ay <= pending_words[0].ay;
                items.az <= pending_words[0].az;
                items.bx <= pending_words[0].bx;
                items.by <= pending_words[0].by;
                items.bz <= pending_words[0].bz;
                items.max_distance <= pending_words[0].max_distance;
                items.last <= pending_words[0].last;
            end
            else
                items.valid <= 1'b0;
            send_gap <= gap;
        end
    end

    // Monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        pick_result_t e;
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: rej %0b found %0b idx %0d dist %0h",
                             $time, results.query_rejected, results.found,
                             results.hit_index, results.hit_distance);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (results.query_rejected !== e.query_rejected)
                    begin
                        $display("%0t: query_rejected expected %0b actual %0b",
                                 $time, e.query_rejected, results.query_rejected);
                        error_count++;
                    end
                    if (results.found !== e.found)
                    begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, e.found, results.found);
                        error_count++;
                    end
                    if (results.hit_index !== e.hit_index)
                    begin
                        $display("%0t: hit_index expected %0d actual %0d",
                                 $time, e.hit_index, results.hit_index);
                        error_count++;
                    end
                    if (results.hit_distance !== e.hit_distance)
                    begin
                        $display("%0t: hit_distance expected %0h actual %0h",
                                 $time, e.hit_distance, results.hit_distance);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                results.ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                recv_gap <= pick_gap();
                results.ready <= 1'b0;
            end
            else
                results.ready <= 1'b1;
        end
    end

    // End of run: stimulus consumed, expectations drained, then a short tail.
    initial
    begin
        int tail;
        tail = 0;
        while (1)
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("ray_box_nearest_pick_tb: errors");
                $finish;
            end
            if (rst_n && pending_words.size() == 0 && !items.valid
                && expected_results.size() == 0)
                tail++;
            else
                tail = 0;
            if (tail > 500)
                break;
        end
        if (error_count == 0)
            $display("ray_box_nearest_pick_tb: clean");
        else
            $display("ray_box_nearest_pick_tb: errors");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rbnp_pkg.sv
rtl/core/rbnp_if.sv
rtl/core/rbnp_front.sv
rtl/core/rbnp_queue.sv
rtl/core/rbnp_divider.sv
rtl/core/rbnp_back.sv
rtl/core/ray_box_nearest_pick.sv
verif/ray_box_nearest_pick_tb.sv
